// ===== rtl/core/hmf_pkg.sv =====
// shared types, codes and constants of the http message framer
package hmf_pkg;

    localparam int COUNT_W = 25;
    localparam int LEN_W   = 32;
    localparam int POS_W   = 4;

    localparam logic [COUNT_W-1:0] MAX_MESSAGE_RESET = 25'd262144;
    localparam logic [POS_W-1:0]   PREFIX_LEN        = 4'd15;
    localparam logic [LEN_W-1:0]   LEN_SATURATED     = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // line terminator progress codes
    localparam logic [1:0] TERM_NONE   = 2'd0;
    localparam logic [1:0] TERM_CR     = 2'd1;
    localparam logic [1:0] TERM_CRLF   = 2'd2;
    localparam logic [1:0] TERM_CRLFCR = 2'd3;

    typedef enum logic [3:0] {
        LEN_SEARCH = 4'b0001,
        LEN_BLANKS = 4'b0010,
        LEN_DIGITS = 4'b0100,
        LEN_DONE   = 4'b1000
    } len_phase_t;

    typedef enum logic [2:0] {
        FRAME_HEADERS = 3'b001,
        FRAME_BODY    = 3'b010,
        FRAME_ERROR   = 3'b100
    } frame_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_connection;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_message;
        logic       too_large;
        logic       dropped;
    } result_t;

    typedef struct packed {
        logic [1:0]       term;
        logic             line_start;
        logic [POS_W-1:0] prefix_pos;
        len_phase_t       len_phase;
        logic [LEN_W-1:0] len_value;
    } hdr_state_t;

    localparam hdr_state_t HDR_RESET = '{
        term:       TERM_NONE,
        line_start: 1'b1,
        prefix_pos: '0,
        len_phase:  LEN_SEARCH,
        len_value:  '0
    };

    // lower-case form of "content-length:"
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                4'd0:    c = 8'h63; // c
                4'd1:    c = 8'h6F; // o
                4'd2:    c = 8'h6E; // n
                4'd3:    c = 8'h74; // t
                4'd4:    c = 8'h65; // e
                4'd5:    c = 8'h6E; // n
                4'd6:    c = 8'h74; // t
                4'd7:    c = 8'h2D; // -
                4'd8:    c = 8'h6C; // l
                4'd9:    c = 8'h65; // e
                4'd10:   c = 8'h6E; // n
                4'd11:   c = 8'h67; // g
                4'd12:   c = 8'h74; // t
                4'd13:   c = 8'h68; // h
                4'd14:   c = 8'h3A; // :
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        begin
            r = b;
            if (b >= 8'h41 && b <= 8'h5A)
            begin
                r = b + 8'h20;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/hmf_header_parse.sv =====
// header scanner: terminator tracking, content-length match and digit accumulation
module hmf_header_parse (
    input  hmf_pkg::hdr_state_t hdr,
    input  logic [7:0]          in_byte,
    output hmf_pkg::hdr_state_t hdr_next,
    output logic                header_end
);
    import hmf_pkg::*;

    logic                is_digit;
    logic [3:0]          digit;
    logic [LEN_W+3:0]    scaled;
    logic [LEN_W-1:0]    accum;
    logic [POS_W-1:0]    pos_inc;
    logic                char_match;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = in_byte[3:0];

    // value * 10 + digit, saturating at 32 bits
    assign scaled = {1'b0, hdr.len_value, 3'b000} + {3'b000, hdr.len_value, 1'b0}
                  + {{LEN_W{1'b0}}, digit};
    assign accum  = (scaled[LEN_W+3:LEN_W] != 4'd0) ? LEN_SATURATED : scaled[LEN_W-1:0];

    assign pos_inc    = hdr.prefix_pos + 4'd1;
    assign char_match = (hdr.prefix_pos < PREFIX_LEN)
                     && (fold_case(in_byte) == prefix_char(hdr.prefix_pos));

    always_comb
    begin
        hdr_next   = hdr;
        header_end = 1'b0;

        case (hdr.len_phase)
            LEN_BLANKS:
            begin
                if (is_digit)
                begin
                    hdr_next.len_value = {{(LEN_W-4){1'b0}}, digit};
                    hdr_next.len_phase = LEN_DIGITS;
                end
                else if (in_byte != CH_SPACE && in_byte != CH_TAB)
                begin
                    hdr_next.len_phase = LEN_DONE;
                end
            end
            LEN_DIGITS:
            begin
                if (is_digit)
                begin
                    hdr_next.len_value = accum;
                end
                else
                begin
                    hdr_next.len_phase = LEN_DONE;
                end
            end
            LEN_SEARCH:
            begin
                if (hdr.line_start)
                begin
                    if (char_match)
                    begin
                        hdr_next.prefix_pos = pos_inc;
                        if (pos_inc == PREFIX_LEN)
                        begin
                            hdr_next.len_phase = LEN_BLANKS;
                        end
                    end
                    else
                    begin
                        hdr_next.line_start = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // only cr lf ends a line
        if (in_byte == CH_CR)
        begin
            hdr_next.term = (hdr.term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
        end
        else if (in_byte == CH_LF)
        begin
            header_end = (hdr.term == TERM_CRLFCR);
            if (hdr.term == TERM_CR || hdr.term == TERM_CRLFCR)
            begin
                hdr_next.term       = TERM_CRLF;
                hdr_next.line_start = 1'b1;
                hdr_next.prefix_pos = '0;
            end
            else
            begin
                hdr_next.term = TERM_NONE;
            end
        end
        else
        begin
            hdr_next.term = TERM_NONE;
        end
    end

endmodule

// ===== rtl/core/http_message_framer_unit.sv =====
// top level of the http message framer: frame tracking, size checks and output skid
// an accepted byte's result is registered in the output register, or in the skid while the output stalls
// throughput: one byte per cycle while the skid is empty; the combinational header scan and size compare set it
// a two-entry output stage (result register plus skid) takes one more byte when the output stalls
// reset: rst_n clears all parse state, the flow control and sets the size limit to 262144
// a new_connection byte clears the parse state ahead of its own processing
module http_message_framer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  hmf_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output hmf_pkg::result_t              result,
    input  logic                          max_bytes_we,
    input  logic [hmf_pkg::COUNT_W-1:0]   max_bytes_wdata
);
    import hmf_pkg::*;

    logic [COUNT_W-1:0] max_bytes_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    frame_phase_t       frame_reg;
    frame_phase_t       frame_next;
    hdr_state_t         hdr_reg;
    hdr_state_t         hdr_next;

    logic               out_valid_reg;
    logic               skid_valid_reg;
    result_t            out_reg;
    result_t            skid_reg;
    result_t            res_next;

    hdr_state_t         hdr_eff;
    hdr_state_t         hdr_scan;
    logic               header_end;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] total_eff;
    frame_phase_t       frame_eff;
    logic [COUNT_W-1:0] count_inc;
    logic [LEN_W:0]     msg_total;

    logic               accept_in;
    logic               out_take;

    assign item_stall   = skid_valid_reg;
    assign accept_in    = item_valid && !skid_valid_reg;
    assign out_take     = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // a new connection starts from clean parse state
    assign hdr_eff   = item.new_connection ? HDR_RESET : hdr_reg;
    assign count_eff = item.new_connection ? '0 : count_reg;
    assign total_eff = item.new_connection ? '0 : total_reg;
    assign frame_eff = item.new_connection ? FRAME_HEADERS : frame_reg;

    assign count_inc = count_eff + 25'd1;
    assign msg_total = {{(LEN_W+1-COUNT_W){1'b0}}, count_inc} + {1'b0, hdr_scan.len_value};

    hmf_header_parse u_parse (
        .hdr        (hdr_eff),
        .in_byte    (item.in_byte),
        .hdr_next   (hdr_scan),
        .header_end (header_end)
    );

    always_comb
    begin
        res_next                 = '0;
        res_next.out_byte        = item.in_byte;
        hdr_next                 = hdr_eff;
        count_next               = count_eff;
        total_next               = total_eff;
        frame_next               = frame_eff;

        case (frame_eff)
            FRAME_ERROR:
            begin
                res_next.dropped = 1'b1;
            end
            FRAME_HEADERS:
            begin
                count_next = count_inc;
                hdr_next   = hdr_scan;
                if (header_end)
                begin
                    if (msg_total > {{(LEN_W+1-COUNT_W){1'b0}}, max_bytes_reg})
                    begin
                        res_next.too_large = 1'b1;
                        frame_next         = FRAME_ERROR;
                        total_next         = msg_total[COUNT_W-1:0];
                    end
                    else if (hdr_scan.len_value == '0)
                    begin
                        // empty body: header end closes the message
                        res_next.last_of_message = 1'b1;
                        hdr_next                 = HDR_RESET;
                        count_next               = '0;
                        total_next               = '0;
                        frame_next               = FRAME_HEADERS;
                    end
                    else
                    begin
                        total_next = msg_total[COUNT_W-1:0];
                        frame_next = FRAME_BODY;
                    end
                end
                else if (count_inc >= max_bytes_reg)
                begin
                    res_next.too_large = 1'b1;
                    frame_next         = FRAME_ERROR;
                end
            end
            default:
            begin
                count_next = count_inc;
                if (count_inc >= total_eff)
                begin
                    res_next.last_of_message = 1'b1;
                    hdr_next                 = HDR_RESET;
                    count_next               = '0;
                    total_next               = '0;
                    frame_next               = FRAME_HEADERS;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_MESSAGE_RESET;
        end
        else if (max_bytes_we)
        begin
            max_bytes_reg <= max_bytes_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg   <= HDR_RESET;
            count_reg <= '0;
            total_reg <= '0;
            frame_reg <= FRAME_HEADERS;
        end
        else if (accept_in)
        begin
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
            total_reg <= total_next;
            frame_reg <= frame_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || accept_in;
            skid_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept_in)
            begin
                out_reg <= res_next;
            end
        end
        else if (accept_in)
        begin
            skid_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot0({result.last_of_message, result.too_large, result.dropped}))
        else $error("more than one status flag on a result");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && frame_reg == FRAME_ERROR && !item.new_connection |-> res_next.dropped)
        else $error("byte not dropped in the error phase");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall && accept_in))
        else $error("skid filled without a stalled output");

    // the limit may be rewritten mid-body, so only the count is bounded here
    a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg == FRAME_BODY |-> count_reg < total_reg)
        else $error("body count beyond the message total");
`endif

endmodule

// ===== tb/http_message_framer_unit_tb.sv =====
// testbench for the http message framer: framed byte streams against a built-in framing predictor
module http_message_framer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmf_pkg::*;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 max_bytes_we = 1'b0;
    logic [COUNT_W-1:0]   max_bytes_wdata = '0;

    http_message_framer_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .max_bytes_we    (max_bytes_we),
        .max_bytes_wdata (max_bytes_wdata)
    );

    string length_key = "content-length:";

    // framing predictor state
    logic [COUNT_W-1:0] lim_bytes;
    logic [COUNT_W-1:0] msg_bytes;
    logic [1:0]         crlf_seen;
    logic               line_match;
    logic [4:0]         key_pos;
    len_phase_t         len_phase;
    logic [LEN_W-1:0]   len_acc;
    logic [32:0]        msg_total;
    frame_phase_t       frame_phase;

    result_t framed_results[$];
    result_t expected_result;
    int      errors = 0;
    int      bytes_sent = 0;
    int      stall_left = 0;
    logic    next_fresh = 1'b0;
    logic    no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL http_message_framer_unit");
        $finish;
    end

    function automatic void clear_state();
        msg_bytes   = '0;
        crlf_seen   = TERM_NONE;
        line_match  = 1'b1;
        key_pos     = '0;
        len_phase   = LEN_SEARCH;
        len_acc     = '0;
        msg_total   = '0;
        frame_phase = FRAME_HEADERS;
    endfunction

    // one header byte: length line parsing and terminator tracking, true at the header end
    function automatic logic scan_header(input logic [7:0] b);
        logic [1:0]  prev;
        logic        is_digit;
        logic [7:0]  lower;
        logic [7:0]  key_ch;
        logic [63:0] wide;
        logic        done;
        prev     = crlf_seen;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        lower    = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        done     = 1'b0;
        case (len_phase)
            LEN_BLANKS:
            begin
                if (is_digit)
                begin
                    len_acc   = {24'd0, b - CH_ZERO};
                    len_phase = LEN_DIGITS;
                end
                else if (b != CH_SPACE && b != CH_TAB)
                begin
                    len_phase = LEN_DONE;
                end
            end
            LEN_DIGITS:
            begin
                if (is_digit)
                begin
                    wide    = {32'd0, len_acc} * 64'd10 + {56'd0, b - CH_ZERO};
                    len_acc = (wide > {32'd0, LEN_SATURATED}) ? LEN_SATURATED : wide[31:0];
                end
                else
                begin
                    len_phase = LEN_DONE;
                end
            end
            LEN_SEARCH:
            begin
                if (line_match)
                begin
                    key_ch = (key_pos < length_key.len()) ? length_key[key_pos] : 8'h00;
                    if (key_pos < length_key.len() && lower == key_ch)
                    begin
                        key_pos = key_pos + 5'd1;
                        if (key_pos == length_key.len())
                        begin
                            len_phase = LEN_BLANKS;
                        end
                    end
                    else
                    begin
                        line_match = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (b == CH_CR)
        begin
            crlf_seen = (prev == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
        end
        else if (b == CH_LF)
        begin
            done = (prev == TERM_CRLFCR);
            if (prev == TERM_CR || prev == TERM_CRLFCR)
            begin
                crlf_seen  = TERM_CRLF;
                line_match = 1'b1;
                key_pos    = '0;
            end
            else
            begin
                crlf_seen = TERM_NONE;
            end
        end
        else
        begin
            crlf_seen = TERM_NONE;
        end
        return done;
    endfunction

    function automatic result_t frame_byte(input item_t it);
        result_t            r;
        logic [COUNT_W-1:0] n;
        logic [32:0]        tot;
        r          = '0;
        r.out_byte = it.in_byte;
        if (it.new_connection)
        begin
            clear_state();
        end
        if (frame_phase == FRAME_ERROR)
        begin
            r.dropped = 1'b1;
        end
        else
        begin
            n         = msg_bytes + 25'd1;
            msg_bytes = n;
            if (frame_phase == FRAME_HEADERS)
            begin
                if (scan_header(it.in_byte))
                begin
                    tot       = {8'd0, n} + {1'b0, len_acc};
                    msg_total = tot;
                    if (tot > {8'd0, lim_bytes})
                    begin
                        r.too_large = 1'b1;
                        frame_phase = FRAME_ERROR;
                    end
                    else if (tot == {8'd0, n})
                    begin
                        r.last_of_message = 1'b1;
                        clear_state();
                    end
                    else
                    begin
                        frame_phase = FRAME_BODY;
                    end
                end
                else if (n >= lim_bytes)
                begin
                    r.too_large = 1'b1;
                    frame_phase = FRAME_ERROR;
                end
            end
            else if ({8'd0, n} >= msg_total)
            begin
                r.last_of_message = 1'b1;
                clear_state();
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    endtask

    // result side: checks every transfer and throws random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (framed_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result expected none actual %h", $time, result);
                end
                else
                begin
                    expected_result = framed_results.pop_front();
                    if (result.out_byte !== expected_result.out_byte)
                        report_field("out_byte", expected_result.out_byte, result.out_byte);
                    if (result.last_of_message !== expected_result.last_of_message)
                        report_field("last_of_message", {7'd0, expected_result.last_of_message},
                                     {7'd0, result.last_of_message});
                    if (result.too_large !== expected_result.too_large)
                        report_field("too_large", {7'd0, expected_result.too_large},
                                     {7'd0, result.too_large});
                    if (result.dropped !== expected_result.dropped)
                        report_field("dropped", {7'd0, expected_result.dropped},
                                     {7'd0, result.dropped});
                end
            end
            if (no_idle)
            begin
                stall_left = 0;
                result_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        item_t it;
        it.in_byte        = b;
        it.new_connection = next_fresh;
        next_fresh        = 1'b0;
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        framed_results.push_back(frame_byte(it));
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            send_byte(s[k]);
        end
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (framed_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        drain();
        max_bytes_wdata <= value;
        max_bytes_we    <= 1'b1;
        @(posedge clk);
        max_bytes_we <= 1'b0;
        lim_bytes = value;
    endtask

    // key in random case, blanks, then a value, no digits or a long one that may saturate
    task automatic send_length_line(input int cap, output int body_len);
        int         mode;
        int         k;
        logic [7:0] c;
        string      digits;
        mode     = $urandom_range(0, 9);
        body_len = 0;
        for (k = 0; k < length_key.len(); k++)
        begin
            c = length_key[k];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
            begin
                c = c - 8'd32;
            end
            send_byte(c);
        end
        repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
        if (mode == 0)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                send_byte("x");
            end
        end
        else if (mode == 1)
        begin
            send_byte(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(9, 13)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else
        begin
            body_len = $urandom_range(0, cap);
            repeat ($urandom_range(0, 2)) send_byte(CH_ZERO);
            digits = $sformatf("%0d", body_len);
            send_string(digits);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            send_byte(";");
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_plain_line();
        int         k;
        int         n;
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0)
        begin
            // partial key match that breaks off
            n = $urandom_range(1, 14);
            for (k = 0; k < n; k++)
            begin
                send_byte(length_key[k]);
            end
            send_byte("Q");
        end
        repeat ($urandom_range(1, 10))
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_CR)
            begin
                c = ".";
            end
            send_byte(c);
        end
    endtask

    task automatic send_message(input int cap);
        int   n_lines;
        int   at;
        int   body;
        int   k;
        logic with_len;
        next_fresh = ($urandom_range(0, 1) == 0);
        n_lines    = $urandom_range(0, 3);
        with_len   = ($urandom_range(0, 3) != 0);
        at         = $urandom_range(0, n_lines);
        body       = 0;
        for (k = 0; k <= n_lines; k++)
        begin
            if (with_len && k == at)
            begin
                send_length_line(cap, body);
                send_crlf();
                if ($urandom_range(0, 5) == 0)
                begin
                    send_string("Content-Length: 9");
                    send_crlf();
                end
            end
            if (k < n_lines)
            begin
                send_plain_line();
                send_crlf();
            end
        end
        send_crlf();
        // now and then the body is one byte off, so framing slips into the next message
        if (body > 0 && $urandom_range(0, 11) == 0)
        begin
            body = body - 1 + 2 * $urandom_range(0, 1);
        end
        repeat (body) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 5))
            begin
                next_fresh = ($urandom_range(0, 3) == 0);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_zero_limit();
        write_limit('0);
        next_fresh = 1'b1;
        send_byte("A");
        send_byte(8'hFF);
    endtask

    task automatic test_empty_bodies();
        write_limit(25'd8);
        next_fresh = 1'b1;
        send_crlf();
        send_crlf();
        // lone lf and lone cr do not end a line
        send_byte("a");
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_crlf();
        send_crlf();
    endtask

    task automatic test_header_overflow();
        next_fresh = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_string("Content");
        send_byte("t");
    endtask

    task automatic test_default_limit();
        write_limit(MAX_MESSAGE_RESET);
        while (bytes_sent < 420) send_message(40);
    endtask

    task automatic test_high_limit();
        write_limit(25'h100_0000);
        while (bytes_sent < 780) send_message(60);
    endtask

    task automatic test_tight_limit();
        write_limit(25'd8);
        while (bytes_sent < 1020) send_message(3);
    endtask

    task automatic test_random_limits();
        int target;
        target = bytes_sent;
        repeat (4)
        begin
            target += 100;
            write_limit(COUNT_W'($urandom_range(30, 150)));
            while (bytes_sent < target) send_message(100);
        end
    endtask

    task automatic test_unthrottled();
        write_limit(25'h1FF_FFFF);
        no_idle = 1'b1;
        while (bytes_sent < 1820) send_message(40);
    endtask

    initial
    begin
        lim_bytes = MAX_MESSAGE_RESET;
        clear_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_limit();
        test_empty_bodies();
        test_header_overflow();
        test_default_limit();
        test_high_limit();
        test_tight_limit();
        test_random_limits();
        test_unthrottled();

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("PASS http_message_framer_unit");
        else
            $display("FAIL http_message_framer_unit");
        $finish;
    end

endmodule
